FILE: rtl/rkb_pkg.sv
`default_nettype none

package rkb_pkg;

  // Configuration register indexes
  localparam logic CFG_STEP_SIZE  = 1'b0;
  localparam logic CFG_LOCKOUT_MS = 1'b1;

  // Reset values and saturation limits
  localparam logic [7:0]  STEP_SIZE_RST  = 8'd10;
  localparam logic [15:0] LOCKOUT_MS_RST = 16'd200;
  localparam logic [7:0]  LEVEL_MAX      = 8'd255;
  localparam logic [15:0] ELAPSED_MAX    = 16'hFFFF;
  localparam logic signed [7:0] NET_MAX  = 8'sd127;
  localparam logic signed [7:0] NET_MIN  = -8'sd128;

  // Transition direction codes
  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_UP   = 2'd1;
  localparam logic [1:0] DIR_DOWN = 2'd2;

  typedef struct packed {
    logic phase_a;
    logic phase_b;
    logic button_level;
    logic ms_tick;
    logic poll;
  } in_item_t;

  typedef struct packed {
    logic [7:0] brightness;
    logic       wake;
    logic       next_pattern;
    logic       button_armed;
  } out_item_t;

  typedef struct packed {
    logic [1:0]        last_phases;
    logic signed [7:0] net_steps;
    logic              moved;
    logic              last_button;
    logic              press_pending;
    logic              armed;
    logic              lockout_running;
    logic [15:0]       lockout_elapsed;
    logic [7:0]        level;
  } rkb_state_t;

  localparam rkb_state_t STATE_RST = '{
    last_phases:     2'b11,
    net_steps:       8'sd0,
    moved:           1'b0,
    last_button:     1'b1,
    press_pending:   1'b0,
    armed:           1'b1,
    lockout_running: 1'b0,
    lockout_elapsed: 16'd0,
    level:           8'd255
  };

  // Decode previous and current phase pair into a step direction
  function automatic logic [1:0] phase_dir(input logic [3:0] trans);
    logic [1:0] dir;
    case (trans) inside
      4'b0001, 4'b0111, 4'b1110, 4'b1000: dir = DIR_UP;
      4'b0010, 4'b1011, 4'b1101, 4'b0100: dir = DIR_DOWN;
      default:                            dir = DIR_NONE;
    endcase
    return dir;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/rkb_step.sv
`default_nettype none

module rkb_step import rkb_pkg::*; (
  input  wire rkb_state_t state_i,
  input  wire in_item_t   item_i,
  input  wire [7:0]       step_size_i,
  input  wire [15:0]      lockout_ms_i,
  output rkb_state_t      state_o,
  output out_item_t       result_o
);

  logic [1:0] dir;
  logic [8:0] sum_up;
  rkb_state_t st;
  logic       wake;
  logic       next_pat;

  assign dir    = phase_dir({state_i.last_phases, item_i.phase_a, item_i.phase_b});
  assign sum_up = {1'b0, state_i.level} + {1'b0, step_size_i};

  always_comb begin
    st       = state_i;
    wake     = 1'b0;
    next_pat = 1'b0;

    // Count the phase transition, saturating
    if (dir == DIR_UP) begin
      if (st.net_steps != NET_MAX) st.net_steps = st.net_steps + 8'sd1;
      st.moved = 1'b1;
    end else if (dir == DIR_DOWN) begin
      if (st.net_steps != NET_MIN) st.net_steps = st.net_steps - 8'sd1;
      st.moved = 1'b1;
    end
    st.last_phases = {item_i.phase_a, item_i.phase_b};

    // Disarm on a falling button edge
    if (st.last_button && !item_i.button_level && st.armed) begin
      st.armed         = 1'b0;
      st.press_pending = 1'b1;
    end
    st.last_button = item_i.button_level;

    // Advance the lockout timer
    if (item_i.ms_tick && st.lockout_running && st.lockout_elapsed != ELAPSED_MAX) begin
      st.lockout_elapsed = st.lockout_elapsed + 16'd1;
    end

    // Service step
    if (item_i.poll) begin
      if (st.moved) begin
        st.moved = 1'b0;
        wake     = 1'b1;
        if (st.net_steps > 8'sd0) begin
          st.level = sum_up[8] ? LEVEL_MAX : sum_up[7:0];
        end else if (st.net_steps < 8'sd0) begin
          st.level = (st.level >= step_size_i) ? st.level - step_size_i : 8'd0;
        end
        st.net_steps = 8'sd0;
      end
      if (st.press_pending) begin
        st.press_pending   = 1'b0;
        st.lockout_running = 1'b1;
        st.lockout_elapsed = 16'd0;
        wake               = 1'b1;
        next_pat           = 1'b1;
      end
      if (st.lockout_running && st.lockout_elapsed > lockout_ms_i) begin
        st.lockout_running = 1'b0;
        st.lockout_elapsed = 16'd0;
        st.armed           = 1'b1;
      end
    end
  end

  assign state_o                = st;
  assign result_o.brightness    = st.level;
  assign result_o.wake          = wake;
  assign result_o.next_pattern  = next_pat;
  assign result_o.button_armed  = st.armed;

endmodule

`default_nettype wire

FILE: rtl/rotary_knob_brightness_control_unit.sv
`default_nettype none

// Channel   Direction  Handshake                 Payload
// in        input      in_valid_i / in_stall_o   in_data_i  (in_item_t)
// out       output     out_valid_o / out_stall_i out_data_o (out_item_t)
// cfg       input      cfg_we_i                  cfg_idx_i, cfg_data_i
//
// One beat in, one beat out; a new beat is taken every cycle unless the result is stalled.
// Data passes the input register, then the decode and service
// logic into the result register, which also holds knob state.
// Reset restores the register defaults and the idle knob state.
// A stalled result holds; input stalls only while both registers are full and the result is stalled.

module rotary_knob_brightness_control_unit import rkb_pkg::*; (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  output logic       in_stall_o,
  input  wire in_item_t in_data_i,
  output logic       out_valid_o,
  input  wire        out_stall_i,
  output out_item_t  out_data_o,
  input  wire        cfg_we_i,
  input  wire        cfg_idx_i,
  input  wire [15:0] cfg_data_i
);

  logic [7:0]  step_size_q;
  logic [15:0] lockout_ms_q;
  logic        in_valid_q;
  in_item_t    in_q;
  logic        out_valid_q;
  out_item_t   out_q;
  rkb_state_t  state_q;
  rkb_state_t  state_d;
  out_item_t   out_d;
  logic        out_ready;
  logic        advance;
  logic        in_load;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_ready;
  assign in_stall_o = in_valid_q && !out_ready;
  assign in_load    = in_valid_i && !in_stall_o;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_size_q  <= STEP_SIZE_RST;
      lockout_ms_q <= LOCKOUT_MS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_STEP_SIZE:  step_size_q  <= cfg_data_i[7:0];
        CFG_LOCKOUT_MS: lockout_ms_q <= cfg_data_i;
        default:        ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_load) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      in_q <= in_data_i;
    end
  end

  rkb_step u_step (
    .state_i      (state_q),
    .item_i       (in_q),
    .step_size_i  (step_size_q),
    .lockout_ms_i (lockout_ms_q),
    .state_o      (state_d),
    .result_o     (out_d)
  );

  // Knob state and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= STATE_RST;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        state_q <= state_d;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A handled press always wakes and leaves the button disarmed
  a_next_wakes : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!out_data_o.next_pattern ||
                     (out_data_o.wake && !out_data_o.button_armed)))
    else $error("next_pattern without wake or with button armed");

  // Input stalls only when the result side is full and stalled
  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled without a blocked result");

  // Brightness only moves on a polled beat
  a_level_poll : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.level != $past(state_q.level)) |-> $past(advance && in_q.poll))
    else $error("brightness changed without a poll");

  // Lockout is idle and no press is pending while the button is armed
  a_armed_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.armed |-> (!state_q.lockout_running && !state_q.press_pending))
    else $error("armed with lockout or press pending");

endmodule

`default_nettype wire
